>>> design/grc_pkg.sv
package grc_pkg;

  // default geometry
  localparam int MAP_WIDTH_D  = 8;
  localparam int MAP_HEIGHT_D = 8;
  localparam int CELL_SIZE_D  = 64;
  localparam int MAX_STEPS_D  = 8;

  // field widths
  localparam int MAP_BITS  = 64;
  localparam int VH_W      = 10;
  localparam int POS_W     = 17;
  localparam int ANG_W     = 16;
  localparam int CDIST_W   = 24;
  localparam int STOP_W    = 9;
  localparam int TRIG_W    = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 64;

  // datapath widths
  localparam int LINE_W = 19;
  localparam int MULA_W = 20;
  localparam int PROD_W = 52;
  localparam int DIV_DW = 50;
  localparam int DIV_VW = 32;
  localparam int D2_W   = 51;
  localparam int CPOS_W = 52;
  localparam int SQ_W   = 36;
  localparam int DIST_W = 18;

  localparam logic [VH_W-1:0] VIEW_HEIGHT_RST = 10'd320;

  localparam logic [CFG_IDX_W-1:0] CFG_WALL_MAP    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = 8'd1;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [TRIG_W-1:0] ONE_Q30     = 32'sd1073741824;
  localparam int CORDIC_N = 15;

  // datapath commands
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
  localparam logic [OP_W-1:0] OP_TRIG_RA   = 5'd2;
  localparam logic [OP_W-1:0] OP_TAKE_RA   = 5'd3;
  localparam logic [OP_W-1:0] OP_WALK_INIT = 5'd4;
  localparam logic [OP_W-1:0] OP_MUL_D1DC  = 5'd5;
  localparam logic [OP_W-1:0] OP_DIV_D2    = 5'd6;
  localparam logic [OP_W-1:0] OP_TAKE_D2   = 5'd7;
  localparam logic [OP_W-1:0] OP_ADVANCE   = 5'd8;
  localparam logic [OP_W-1:0] OP_HIT       = 5'd9;
  localparam logic [OP_W-1:0] OP_SQ1       = 5'd10;
  localparam logic [OP_W-1:0] OP_SQ2       = 5'd11;
  localparam logic [OP_W-1:0] OP_SQRT      = 5'd12;
  localparam logic [OP_W-1:0] OP_TAKE_DIST = 5'd13;
  localparam logic [OP_W-1:0] OP_TRIG_DIFF = 5'd14;
  localparam logic [OP_W-1:0] OP_CORR      = 5'd15;
  localparam logic [OP_W-1:0] OP_DIV_H     = 5'd16;
  localparam logic [OP_W-1:0] OP_H_FULL    = 5'd17;
  localparam logic [OP_W-1:0] OP_TAKE_H    = 5'd18;
  localparam logic [OP_W-1:0] OP_LOAD_OUT  = 5'd19;
  localparam logic [OP_W-1:0] OP_LOAD_MISS = 5'd20;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            walk_sel;  // 0: horizontal lines, 1: vertical lines
  } grc_cmd_t;

  typedef struct packed {
    logic trig_done;
    logic div_done;
    logic sqrt_done;
    logic dir_zero;
    logic im_out;
    logic cell_out;
    logic wall;
    logic last_step;
    logic found_any;
    logic corr_zero;
    logic out_busy;
  } grc_sts_t;

  function automatic logic signed [17:0] cordic_arc(input logic [3:0] i);
    case (i)
      4'd0:    return 18'sd8192;
      4'd1:    return 18'sd4836;
      4'd2:    return 18'sd2555;
      4'd3:    return 18'sd1297;
      4'd4:    return 18'sd651;
      4'd5:    return 18'sd326;
      4'd6:    return 18'sd163;
      4'd7:    return 18'sd81;
      4'd8:    return 18'sd41;
      4'd9:    return 18'sd20;
      4'd10:   return 18'sd10;
      4'd11:   return 18'sd5;
      4'd12:   return 18'sd3;
      4'd13:   return 18'sd1;
      4'd14:   return 18'sd1;
      default: return 18'sd0;
    endcase
  endfunction

  // shift that truncates toward zero
  function automatic logic signed [TRIG_W-1:0] sra_tz(input logic signed [TRIG_W-1:0] v,
                                                      input logic [3:0] n);
    logic signed [TRIG_W-1:0] m;
    m = -v;
    if (v[TRIG_W-1]) return -(m >>> n);
    return v >>> n;
  endfunction

endpackage

>>> design/grc_ifs.sv
interface grc_req_if import grc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] player_x;
  logic [POS_W-1:0] player_y;
  logic [ANG_W-1:0] player_heading;
  logic [ANG_W-1:0] ray_angle;
  modport source(output valid, player_x, player_y, player_heading, ray_angle, input ready);
  modport sink(input valid, player_x, player_y, player_heading, ray_angle, output ready);
endinterface

interface grc_rsp_if import grc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   hit_x;
  logic [POS_W-1:0]   hit_y;
  logic [CDIST_W-1:0] corrected_distance;
  logic               hit_vertical;
  logic               wall_found;
  logic [VH_W-1:0]    strip_height;
  logic [STOP_W-1:0]  strip_top;
  modport source(output valid, hit_x, hit_y, corrected_distance, hit_vertical, wall_found,
                 strip_height, strip_top, input ready);
  modport sink(input valid, hit_x, hit_y, corrected_distance, hit_vertical, wall_found,
               strip_height, strip_top, output ready);
endinterface

interface grc_cfg_if import grc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> design/grid_raycast_column.sv
// Channel | Dir | Beat contents
// --------+-----+--------------------------------------------------------------
// cfg     | in  | index, data: 0 = wall_map (64 b), 1 = view_height (10 b)
// req     | in  | player_x, player_y, player_heading, ray_angle
// rsp     | out | hit_x, hit_y, corrected_distance, hit_vertical, wall_found,
//         |     | strip_height, strip_top
//
// One ray at a time. Each beat runs the ray-angle CORDIC, then per grid line
// tested a multiply plus a restoring divide for the crossing point, plus, per
// walk that hits, squares and an 18-step square root, then the fisheye CORDIC
// and strip divide. The shared divider takes most of each beat.
// Reset (rst, synchronous) clears the controller, unit flags and output
// valid; wall_map returns to 0 and view_height to 320.
// rsp is registered; a new req beat is taken while a finished beat waits on
// rsp, and the controller only stalls when it needs that register again.
module grid_raycast_column import grc_pkg::*; #(
  parameter int MAP_WIDTH  = MAP_WIDTH_D,
  parameter int MAP_HEIGHT = MAP_HEIGHT_D,
  parameter int CELL_SIZE  = CELL_SIZE_D,
  parameter int MAX_STEPS  = MAX_STEPS_D
) (
  input  logic      clk,
  input  logic      rst,
  grc_cfg_if.sink   cfg,
  grc_req_if.sink   req,
  grc_rsp_if.source rsp
);

  grc_cmd_t cmd;
  grc_sts_t sts;
  logic     req_ready;

  assign req.ready = req_ready;

  // sequencer: trig, horizontal walk, vertical walk, select, strip
  grc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // registers, CORDIC, divider, multiplier, square root, output register
  grc_dp #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT),
    .CELL_SIZE  (CELL_SIZE),
    .MAX_STEPS  (MAX_STEPS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

endmodule

>>> design/grc_cordic.sv
module grc_cordic import grc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ANG_W-1:0]         angle,
  output logic                     done,
  output logic signed [TRIG_W-1:0] co,
  output logic signed [TRIG_W-1:0] si
);

  logic signed [TRIG_W-1:0] x;
  logic signed [TRIG_W-1:0] y;
  logic signed [17:0]       z;
  logic [3:0]               it;
  logic                     busy;
  logic                     flip;

  assign co = flip ? -x : x;
  assign si = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= (angle[13:0] != 14'd0);
        done <= (angle[13:0] == 14'd0);
      end else if (busy && it == 4'(CORDIC_N - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      it <= 4'd0;
      if (angle[13:0] == 14'd0) begin
        // exact axis: no rotation needed
        flip <= 1'b0;
        z    <= 18'sd0;
        x    <= (angle[15:14] == 2'd0) ? ONE_Q30 : (angle[15:14] == 2'd2) ? -ONE_Q30 : '0;
        y    <= (angle[15:14] == 2'd1) ? ONE_Q30 : (angle[15:14] == 2'd3) ? -ONE_Q30 : '0;
      end else begin
        x <= CORDIC_GAIN;
        y <= '0;
        if (angle > 16'd16384 && angle < 16'd49152) begin
          z    <= $signed({2'b00, angle}) - 18'sd32768;
          flip <= 1'b1;
        end else if (angle >= 16'd49152) begin
          z    <= $signed({2'b00, angle}) - 18'sd65536;
          flip <= 1'b0;
        end else begin
          z    <= $signed({2'b00, angle});
          flip <= 1'b0;
        end
      end
    end else if (busy) begin
      it <= it + 4'd1;
      if (!z[17]) begin
        x <= x - sra_tz(y, it);
        y <= y + sra_tz(x, it);
        z <= z - cordic_arc(it);
      end else begin
        x <= x + sra_tz(y, it);
        y <= y - sra_tz(x, it);
        z <= z + cordic_arc(it);
      end
    end
  end

endmodule

>>> design/grc_div.sv
module grc_div import grc_pkg::*; #(
  parameter int DW = DIV_DW,
  parameter int VW = DIV_VW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [VW-1:0]    rem;
  logic [VW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [VW:0]      rs;

  // restoring, one quotient bit per cycle
  assign rs = {rem, quotient[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
      cnt      <= CNT_W'(DW);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (rs >= {1'b0, dvs}) begin
        rem      <= VW'(rs - {1'b0, dvs});
        quotient <= {quotient[DW-2:0], 1'b1};
      end else begin
        rem      <= rs[VW-1:0];
        quotient <= {quotient[DW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> design/grc_ctrl.sv
module grc_ctrl import grc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  grc_sts_t sts,
  output grc_cmd_t cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_TRIG1   = 5'd1;
  localparam logic [4:0] S_TRIG1_W = 5'd2;
  localparam logic [4:0] S_WINIT   = 5'd3;
  localparam logic [4:0] S_STEP    = 5'd4;
  localparam logic [4:0] S_DIV     = 5'd5;
  localparam logic [4:0] S_DIV_W   = 5'd6;
  localparam logic [4:0] S_CHECK   = 5'd7;
  localparam logic [4:0] S_SQ1     = 5'd8;
  localparam logic [4:0] S_SQ2     = 5'd9;
  localparam logic [4:0] S_SQRT    = 5'd10;
  localparam logic [4:0] S_SQRT_W  = 5'd11;
  localparam logic [4:0] S_WEND    = 5'd12;
  localparam logic [4:0] S_SELECT  = 5'd13;
  localparam logic [4:0] S_TRIG2_W = 5'd14;
  localparam logic [4:0] S_STRIP   = 5'd15;
  localparam logic [4:0] S_HDIV_W  = 5'd16;
  localparam logic [4:0] S_FIN     = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       walk_sel;
  logic       walk_sel_next;

  assign req_ready    = (state == S_IDLE);
  assign cmd.walk_sel = walk_sel;

  always_comb begin
    state_next    = state;
    walk_sel_next = walk_sel;
    cmd.op        = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op        = OP_LOAD;
          walk_sel_next = 1'b0;
          state_next    = S_TRIG1;
        end
      end
      S_TRIG1: begin
        cmd.op     = OP_TRIG_RA;
        state_next = S_TRIG1_W;
      end
      S_TRIG1_W: begin
        if (sts.trig_done) begin
          cmd.op     = OP_TAKE_RA;
          state_next = S_WINIT;
        end
      end
      S_WINIT: begin
        if (sts.dir_zero) begin
          state_next = S_WEND;
        end else begin
          cmd.op     = OP_WALK_INIT;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.im_out) begin
          state_next = S_WEND;
        end else begin
          cmd.op     = OP_MUL_D1DC;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op     = OP_DIV_D2;
        state_next = S_DIV_W;
      end
      S_DIV_W: begin
        if (sts.div_done) begin
          cmd.op     = OP_TAKE_D2;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.cell_out) begin
          state_next = S_WEND;
        end else if (sts.wall) begin
          cmd.op     = OP_HIT;
          state_next = S_SQ1;
        end else begin
          cmd.op     = OP_ADVANCE;
          state_next = sts.last_step ? S_WEND : S_STEP;
        end
      end
      S_SQ1: begin
        cmd.op     = OP_SQ1;
        state_next = S_SQ2;
      end
      S_SQ2: begin
        cmd.op     = OP_SQ2;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op     = OP_SQRT;
        state_next = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (sts.sqrt_done) begin
          cmd.op     = OP_TAKE_DIST;
          state_next = S_WEND;
        end
      end
      S_WEND: begin
        if (!walk_sel) begin
          walk_sel_next = 1'b1;
          state_next    = S_WINIT;
        end else begin
          state_next = S_SELECT;
        end
      end
      S_SELECT: begin
        if (sts.found_any) begin
          cmd.op     = OP_TRIG_DIFF;
          state_next = S_TRIG2_W;
        end else if (!sts.out_busy) begin
          cmd.op     = OP_LOAD_MISS;
          state_next = S_IDLE;
        end
      end
      S_TRIG2_W: begin
        if (sts.trig_done) begin
          cmd.op     = OP_CORR;
          state_next = S_STRIP;
        end
      end
      S_STRIP: begin
        if (sts.corr_zero) begin
          cmd.op     = OP_H_FULL;
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_DIV_H;
          state_next = S_HDIV_W;
        end
      end
      S_HDIV_W: begin
        if (sts.div_done) begin
          cmd.op     = OP_TAKE_H;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.op     = OP_LOAD_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      walk_sel <= 1'b0;
    end else begin
      state    <= state_next;
      walk_sel <= walk_sel_next;
    end
  end

endmodule

>>> design/grc_dp.sv
module grc_dp import grc_pkg::*; #(
  parameter int MAP_WIDTH  = MAP_WIDTH_D,
  parameter int MAP_HEIGHT = MAP_HEIGHT_D,
  parameter int CELL_SIZE  = CELL_SIZE_D,
  parameter int MAX_STEPS  = MAX_STEPS_D
) (
  input  logic     clk,
  input  logic     rst,
  input  grc_cmd_t cmd,
  output grc_sts_t sts,
  grc_cfg_if.sink   cfg,
  grc_req_if.sink   req,
  grc_rsp_if.source rsp
);

  localparam int CELL_Q = CELL_SIZE * 256;
  localparam int K_W    = $clog2(MAX_STEPS + 1);

  // registers
  logic [MAP_BITS-1:0]      wall_map;
  logic [VH_W-1:0]          view_height;
  logic [POS_W-1:0]         px;
  logic [POS_W-1:0]         py;
  logic [ANG_W-1:0]         head;
  logic [ANG_W-1:0]         ra;
  logic signed [TRIG_W-1:0] c;
  logic signed [TRIG_W-1:0] s;
  logic signed [LINE_W-1:0] line;
  logic signed [6:0]        im;
  logic [K_W-1:0]           k;
  logic signed [PROD_W-1:0] prod;
  logic [SQ_W-1:0]          acc;
  logic signed [D2_W-1:0]   d2;
  logic                     q_neg;
  logic                     fh;
  logic                     fv;
  logic [POS_W-1:0]         hx;
  logic [POS_W-1:0]         hy;
  logic [POS_W-1:0]         vx;
  logic [POS_W-1:0]         vy;
  logic [DIST_W-1:0]        dh;
  logic [DIST_W-1:0]        dv;
  logic                     cd_pos;
  logic [CDIST_W-1:0]       corr;
  logic [VH_W-1:0]          h;
  logic                     out_valid;
  logic [SQ_W-1:0]          sq_v;
  logic [SQ_W-1:0]          sq_r;
  logic [SQ_W-1:0]          sq_b;
  logic                     sq_busy;
  logic                     sq_done;

  // combinational
  logic                     sdir_pos, sdir_neg, cdir_pos, cdir_neg;
  logic                     dir_pos, dir_neg;
  logic [POS_W-1:0]         pm, pc;
  logic signed [TRIG_W-1:0] dm, dc;
  logic [3:0]               nm, nc;
  logic signed [LINE_W-1:0] d1;
  logic [5:0]               q0;
  logic signed [CPOS_W-1:0] cpos;
  logic [2:0]               ic;
  logic [2:0]               imc;
  logic [5:0]               idx;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [TRIG_W-1:0] mul_b;
  logic                     mul_en;
  logic [DIV_DW-1:0]        div_a;
  logic [DIV_VW-1:0]        div_b;
  logic [DIV_DW-1:0]        div_q;
  logic                     div_done;
  logic [DIV_DW-1:0]        prod_mag;
  logic [DIV_VW-1:0]        dm_mag;
  logic                     trig_start;
  logic [ANG_W-1:0]         trig_ang;
  logic                     trig_done;
  logic signed [TRIG_W-1:0] t_co, t_si;
  logic signed [TRIG_W-1:0] c_f, s_f;
  logic                     vert;
  logic [DIST_W-1:0]        near_dist;
  logic [CDIST_W-1:0]       corr_c;
  logic [SQ_W-1:0]          sq_sum;

  // ray direction signs from the angle's quadrant
  assign sdir_pos = (ra != '0) && !ra[ANG_W-1];
  assign sdir_neg = ra > 16'd32768;
  assign cdir_pos = (ra < 16'd16384) || (ra > 16'd49152);
  assign cdir_neg = (ra > 16'd16384) && (ra < 16'd49152);

  // walk operand selection
  assign dir_pos = cmd.walk_sel ? cdir_pos : sdir_pos;
  assign dir_neg = cmd.walk_sel ? cdir_neg : sdir_neg;
  assign pm      = cmd.walk_sel ? px : py;
  assign pc      = cmd.walk_sel ? py : px;
  assign dm      = cmd.walk_sel ? c : s;
  assign dc      = cmd.walk_sel ? s : c;
  assign nm      = cmd.walk_sel ? 4'(MAP_WIDTH) : 4'(MAP_HEIGHT);
  assign nc      = cmd.walk_sel ? 4'(MAP_HEIGHT) : 4'(MAP_WIDTH);

  assign d1   = line - $signed({2'b00, pm});
  assign cpos = $signed({{(CPOS_W-POS_W){1'b0}}, pc}) + CPOS_W'(d2);
  assign imc  = im[2:0];

  always_comb begin
    q0 = '0;
    for (int j = 1; j < 32; j++) begin
      if (32'(pm) >= 32'(j * CELL_Q)) q0 = 6'(j);
    end
    ic = '0;
    for (int j = 1; j < 8; j++) begin
      if (cpos[POS_W-1:0] >= 17'(j * CELL_Q)) ic = 3'(j);
    end
  end

  assign idx = cmd.walk_sel ? 6'(ic * MAP_WIDTH + imc) : 6'(imc * MAP_WIDTH + ic);

  // nearer hit, ties to horizontal
  assign vert      = fv && (!fh || dv < dh);
  assign near_dist = vert ? dv : dh;

  assign corr_c = cd_pos ? CDIST_W'(prod[PROD_W-1:30]) : '0;

  // shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_MUL_D1DC: begin
        mul_a = MULA_W'(d1);
        mul_b = dc;
      end
      OP_SQ1: begin
        mul_a = MULA_W'(d1);
        mul_b = TRIG_W'(d1);
      end
      OP_SQ2: begin
        mul_a = $signed(d2[MULA_W-1:0]);
        mul_b = TRIG_W'($signed(d2[MULA_W-1:0]));
      end
      OP_CORR: begin
        mul_a = $signed({2'b00, near_dist});
        mul_b = t_co;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= mul_a * mul_b;
  end

  // divider operands
  assign prod_mag = prod[PROD_W-1] ? DIV_DW'(-prod) : DIV_DW'(prod);
  assign dm_mag   = dm[TRIG_W-1] ? DIV_VW'(-dm) : DIV_VW'(dm);
  assign div_a    = (cmd.op == OP_DIV_H) ? DIV_DW'(CELL_Q * view_height) : prod_mag;
  assign div_b    = (cmd.op == OP_DIV_H) ? DIV_VW'(corr_c) : dm_mag;

  grc_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIV_D2 || cmd.op == OP_DIV_H),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign trig_start = (cmd.op == OP_TRIG_RA) || (cmd.op == OP_TRIG_DIFF);
  assign trig_ang   = (cmd.op == OP_TRIG_DIFF) ? head - ra : ra;

  grc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (trig_start),
    .angle (trig_ang),
    .done  (trig_done),
    .co    (t_co),
    .si    (t_si)
  );

  // near-axis components forced to a unit of the true sign
  always_comb begin
    s_f = t_si;
    c_f = t_co;
    if (sdir_pos && t_si < 32'sd1) s_f = 32'sd1;
    if (sdir_neg && t_si > -32'sd1) s_f = -32'sd1;
    if (cdir_pos && t_co < 32'sd1) c_f = 32'sd1;
    if (cdir_neg && t_co > -32'sd1) c_f = -32'sd1;
  end

  // integer square root, two bits of radicand per cycle
  assign sq_sum = acc + prod[SQ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else begin
      sq_done <= 1'b0;
      if (cmd.op == OP_SQRT) begin
        sq_busy <= 1'b1;
      end else if (sq_busy && sq_b[0]) begin
        sq_busy <= 1'b0;
        sq_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQRT) begin
      sq_v <= sq_sum;
      sq_r <= '0;
      sq_b <= SQ_W'(1) << (SQ_W - 2);
    end else if (sq_busy) begin
      sq_b <= sq_b >> 2;
      if (sq_v >= sq_r + sq_b) begin
        sq_v <= sq_v - (sq_r + sq_b);
        sq_r <= (sq_r >> 1) + sq_b;
      end else begin
        sq_r <= sq_r >> 1;
      end
    end
  end

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_map    <= '0;
      view_height <= VIEW_HEIGHT_RST;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_WALL_MAP) wall_map <= cfg.data;
      if (cfg.index == CFG_VIEW_HEIGHT) view_height <= cfg.data[VH_W-1:0];
    end
  end

  // walk and result datapath
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        px   <= req.player_x;
        py   <= req.player_y;
        head <= req.player_heading;
        ra   <= req.ray_angle;
        fh   <= 1'b0;
        fv   <= 1'b0;
      end
      OP_TAKE_RA: begin
        c <= c_f;
        s <= s_f;
      end
      OP_WALK_INIT: begin
        k    <= '0;
        line <= LINE_W'((32'(q0) + 32'(dir_pos)) * CELL_Q);
        im   <= $signed({1'b0, q0}) + 7'(dir_pos) - 7'(dir_neg);
      end
      OP_DIV_D2: q_neg <= prod[PROD_W-1] ^ dm[TRIG_W-1];
      OP_TAKE_D2: begin
        d2 <= q_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      end
      OP_ADVANCE: begin
        k <= k + K_W'(1);
        if (dir_pos) begin
          line <= line + LINE_W'(CELL_Q);
          im   <= im + 7'sd1;
        end else begin
          line <= line - LINE_W'(CELL_Q);
          im   <= im - 7'sd1;
        end
      end
      OP_HIT: begin
        if (cmd.walk_sel) begin
          fv <= 1'b1;
          vx <= line[POS_W-1:0];
          vy <= cpos[POS_W-1:0];
        end else begin
          fh <= 1'b1;
          hy <= line[POS_W-1:0];
          hx <= cpos[POS_W-1:0];
        end
      end
      OP_SQ2: acc <= prod[SQ_W-1:0];
      OP_TAKE_DIST: begin
        if (cmd.walk_sel) dv <= sq_r[DIST_W-1:0];
        else dh <= sq_r[DIST_W-1:0];
      end
      OP_CORR: cd_pos <= (t_co > 32'sd0);
      OP_DIV_H: corr <= corr_c;
      OP_H_FULL: begin
        corr <= corr_c;
        h    <= view_height;
      end
      OP_TAKE_H: begin
        h <= (div_q > DIV_DW'(view_height)) ? view_height : div_q[VH_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_LOAD_OUT || cmd.op == OP_LOAD_MISS) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_OUT) begin
      rsp.hit_x              <= vert ? vx : hx;
      rsp.hit_y              <= vert ? vy : hy;
      rsp.corrected_distance <= corr;
      rsp.hit_vertical       <= vert;
      rsp.wall_found         <= 1'b1;
      rsp.strip_height       <= h;
      rsp.strip_top          <= view_height[VH_W-1:1] - h[VH_W-1:1];
    end else if (cmd.op == OP_LOAD_MISS) begin
      rsp.hit_x              <= '0;
      rsp.hit_y              <= '0;
      rsp.corrected_distance <= '0;
      rsp.hit_vertical       <= 1'b0;
      rsp.wall_found         <= 1'b0;
      rsp.strip_height       <= '0;
      rsp.strip_top          <= view_height[VH_W-1:1];
    end
  end

  assign rsp.valid = out_valid;

  // status
  assign sts.trig_done = trig_done;
  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sq_done;
  assign sts.dir_zero  = !dir_pos && !dir_neg;
  assign sts.im_out    = im[6] || (im >= $signed({3'b000, nm}));
  assign sts.cell_out  = cpos[CPOS_W-1] || (cpos >= CPOS_W'(nc * CELL_Q));
  assign sts.wall      = wall_map[idx];
  assign sts.last_step = (k == K_W'(MAX_STEPS - 1));
  assign sts.found_any = fh || fv;
  assign sts.corr_zero = (corr_c == '0);
  assign sts.out_busy  = out_valid && !rsp.ready;

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_ADVANCE) |-> (k < K_W'(MAX_STEPS)))
    else $error("grid step count past limit");

  a_hit_needs_walk: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD_OUT) |-> (fh || fv))
    else $error("hit result loaded with no walk hit");

  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD_MISS) |=> (!rsp.wall_found && rsp.strip_height == '0))
    else $error("miss result carries hit data");

  a_strip_clamp: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD_OUT) |=> (rsp.strip_height <= view_height))
    else $error("strip height above view height");
`endif

endmodule
